### rtl/core/cupp_pkg.sv
package cupp_pkg;

  typedef enum logic [4:0] {
    PH_IDLE, PH_EAT_CNT, PH_EAT_PAIR, PH_CELL_ID, PH_X, PH_Y, PH_SIZE, PH_FLAGS,
    PH_EXT, PH_COLOR, PH_SKIN, PH_NAME, PH_OWNER, PH_TYPE, PH_PARTY, PH_ACCT,
    PH_REM_CNT, PH_REM_ID, PH_END
  } phase_e;

  typedef enum logic [3:0] {
    CK_EAT, CK_CELL, CK_AFTER_ID, CK_AFTER_BODY, CK_AFTER_FLAGS, CK_COLOR,
    CK_SKIN, CK_NAME, CK_OWNER, CK_TYPE, CK_PARTY, CK_ACCT, CK_REM, CK_REM_LOOP
  } check_e;

  localparam logic [1:0] KIND_EAT    = 2'd0;
  localparam logic [1:0] KIND_CELL   = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;
  localparam logic [1:0] KIND_DONE   = 2'd3;

  localparam logic [7:0] FLAG_COLOR = 8'h02;
  localparam logic [7:0] FLAG_SKIN  = 8'h04;
  localparam logic [7:0] FLAG_NAME  = 8'h08;
  localparam logic [7:0] FLAG_OWNER = 8'h40;
  localparam logic [7:0] FLAG_EXT   = 8'h80;
  localparam logic [7:0] EXT_ACCT   = 8'h04;
  localparam logic [15:0] TYPE_NONE = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [31:0] primary_id;
    logic [31:0] second_word;
    logic [31:0] y_position;
    logic [15:0] cell_size;
    logic [15:0] flag_bytes;
    logic [24:0] color_word;
    logic [31:0] acct_id;
    logic [31:0] skin_span;
    logic [31:0] name_span;
    logic [31:0] owner_and_type;
    logic        last_of_run;
  } rec_t;

endpackage

### rtl/core/cupp_in_if.sv
interface cupp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [15:0] packet_length;

  modport source (output valid, data_byte, packet_length, input ready);
  modport sink (input valid, data_byte, packet_length, output ready);
endinterface

### rtl/core/cupp_out_if.sv
interface cupp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         record_kind;
  logic [31:0]        primary_id;
  logic [31:0]        second_word;
  logic signed [31:0] y_position;
  logic [15:0]        cell_size;
  logic [15:0]        flag_bytes;
  logic [24:0]        color_word;
  logic [31:0]        acct_id;
  logic [31:0]        skin_span;
  logic [31:0]        name_span;
  logic [31:0]        owner_and_type;
  logic               last_of_run;

  modport source (output valid, record_kind, primary_id, second_word, y_position, cell_size,
                  flag_bytes, color_word, acct_id, skin_span, name_span, owner_and_type,
                  last_of_run, input ready);
  modport sink (input valid, record_kind, primary_id, second_word, y_position, cell_size,
                flag_bytes, color_word, acct_id, skin_span, name_span, owner_and_type,
                last_of_run, output ready);
endinterface

### rtl/core/cupp_cfg_if.sv
interface cupp_cfg_if;
  logic valid;
  logic ready;
  logic legacy_mode;

  modport source (output valid, legacy_mode, input ready);
  modport sink (input valid, legacy_mode, output ready);
endinterface

### rtl/core/cell_update_packet_parser.sv
// channel | dir | payload                               | accepted when
// in_i    | in  | data_byte, packet_length              | valid && ready
// out_o   | out | record fields, last_of_run            | valid && ready
// cfg_i   | in  | legacy_mode                           | valid && ready
//
// One byte is parsed per cycle while in_i.ready is high; a byte may yield up to two records.
// Records enter a four-entry output queue; in_i.ready is high while two slots are free,
// so one byte per cycle is sustained while the sink takes one record per cycle.
// rst_ni clears the parse state, counters, queue and legacy_mode.
// A stalled sink fills the queue and then holds in_i.ready low.
module cell_update_packet_parser
  import cupp_pkg::*;
#(
  parameter int MAX_EAT_PAIRS    = 512,
  parameter int MAX_CELL_RECORDS = 2048,
  parameter int MAX_REMOVALS     = 512
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cupp_in_if.sink    in_i,
  cupp_cfg_if.sink   cfg_i,
  cupp_out_if.source out_o
);

  localparam int EW = $clog2(MAX_EAT_PAIRS + 1);
  localparam int CW = $clog2(MAX_CELL_RECORDS + 1);
  localparam int RW = $clog2(MAX_REMOVALS + 1);
  localparam logic [EW-1:0] EatMax  = EW'(MAX_EAT_PAIRS);
  localparam logic [CW-1:0] CellMax = CW'(MAX_CELL_RECORDS);
  localparam logic [RW-1:0] RemMax  = RW'(MAX_REMOVALS);

  phase_e        phase_q, phase_d;
  logic [15:0]   off_q, off_d, len_q, len_d, sr_q, sr_d;
  logic [2:0]    fbi_q, fbi_d;
  logic [EW-1:0] eat_q, eat_d;
  logic [CW-1:0] cell_q, cell_d;
  logic [RW-1:0] rem_q, rem_d;
  logic [31:0]   ra_q [10];
  logic [31:0]   ra_d [10];
  logic          legacy_q;

  rec_t          fifo_q [4];
  logic [1:0]    wp_q, rp_q;
  logic [2:0]    cnt_q;
  rec_t          r0, r1;
  logic [1:0]    n_push;
  logic          in_acc, out_acc;

  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;
  assign in_i.ready = (cnt_q <= 3'd2);
  assign cfg_i.ready = 1'b1;

  function automatic logic [31:0] ins(logic [31:0] w, logic [7:0] b, logic [4:0] sh);
    ins = w | ({24'd0, b} << sh);
  endfunction

  function automatic logic fits(logic [15:0] p, logic [15:0] len, logic [4:0] n);
    fits = ({1'b0, p} + {12'd0, n}) <= {1'b0, len};
  endfunction

  always_comb begin
    logic [7:0] b;
    logic [7:0] f;
    logic       st;
    logic       run;
    check_e     ck;
    rec_t       x;

    b = in_i.data_byte;
    phase_d = phase_q;
    off_d = off_q;
    len_d = len_q;
    sr_d = sr_q;
    fbi_d = fbi_q;
    eat_d = eat_q;
    cell_d = cell_q;
    rem_d = rem_q;
    ra_d = ra_q;
    st = 1'b0;
    run = 1'b0;
    ck = CK_EAT;
    f = '0;
    x = '0;
    r0 = '0;
    r1 = '0;
    n_push = 2'd0;

    if (in_acc) begin
      if (phase_d == PH_IDLE) begin
        len_d = (in_i.packet_length == 16'd0) ? 16'd1 : in_i.packet_length;
        off_d = '0;
        eat_d = '0;
        cell_d = '0;
        rem_d = '0;
        sr_d = '0;
        fbi_d = '0;
        phase_d = (len_d < 16'd2) ? PH_END : PH_EAT_CNT;
      end
      off_d = off_d + 16'd1;

      case (phase_d)
        PH_EAT_CNT, PH_REM_CNT: begin
          if (fbi_d[0]) sr_d[15:8] = sr_d[15:8] | b;
          else sr_d[7:0] = sr_d[7:0] | b;
          if (fbi_d[0]) begin
            fbi_d = '0;
            st = 1'b1;
            ck = (phase_d == PH_EAT_CNT) ? CK_EAT : CK_REM_LOOP;
          end else begin
            fbi_d = fbi_d + 3'd1;
          end
        end
        PH_EAT_PAIR: begin
          ra_d[fbi_d[2]] = ins(ra_d[fbi_d[2]], b, {fbi_d[1:0], 3'b000});
          if (fbi_d == 3'd7) begin
            fbi_d = '0;
            x = '0;
            x.record_kind = KIND_EAT;
            x.primary_id = ra_d[0];
            x.second_word = ra_d[1];
            r0 = x;
            n_push = 2'd1;
            eat_d = eat_d + EW'(1);
            sr_d = sr_d - 16'd1;
            st = 1'b1;
            ck = CK_EAT;
          end else begin
            fbi_d = fbi_d + 3'd1;
          end
        end
        PH_CELL_ID, PH_X, PH_Y, PH_ACCT, PH_REM_ID: begin
          case (phase_d)
            PH_X: ra_d[1] = ins(ra_d[1], b, {fbi_d[1:0], 3'b000});
            PH_Y: ra_d[2] = ins(ra_d[2], b, {fbi_d[1:0], 3'b000});
            PH_ACCT: ra_d[6] = ins(ra_d[6], b, {fbi_d[1:0], 3'b000});
            default: ra_d[0] = ins(ra_d[0], b, {fbi_d[1:0], 3'b000});
          endcase
          if (fbi_d == 3'd3) begin
            fbi_d = '0;
            case (phase_d)
              PH_CELL_ID: begin
                st = 1'b1;
                ck = CK_AFTER_ID;
              end
              PH_X: begin
                phase_d = PH_Y;
                ra_d[2] = '0;
              end
              PH_Y: begin
                phase_d = PH_SIZE;
                ra_d[3] = '0;
              end
              PH_ACCT: begin
                x = '0;
                x.record_kind = KIND_CELL;
                x.primary_id = ra_d[0];
                x.second_word = ra_d[1];
                x.y_position = ra_d[2];
                x.cell_size = ra_d[3][15:0];
                x.flag_bytes = ra_d[4][15:0];
                x.color_word = ra_d[5][24:0];
                x.acct_id = ra_d[6];
                x.skin_span = ra_d[7];
                x.name_span = ra_d[8];
                x.owner_and_type = ra_d[9];
                r0 = x;
                n_push = 2'd1;
                cell_d = cell_d + CW'(1);
                st = 1'b1;
                ck = CK_CELL;
              end
              default: begin
                x = '0;
                x.record_kind = KIND_REMOVE;
                x.primary_id = ra_d[0];
                r0 = x;
                n_push = 2'd1;
                rem_d = rem_d + RW'(1);
                sr_d = sr_d - 16'd1;
                st = 1'b1;
                ck = CK_REM_LOOP;
              end
            endcase
          end else begin
            fbi_d = fbi_d + 3'd1;
          end
        end
        PH_SIZE, PH_OWNER, PH_TYPE: begin
          case (phase_d)
            PH_SIZE: ra_d[3] = ins(ra_d[3], b, {1'b0, fbi_d[0], 3'b000});
            PH_OWNER: ra_d[9] = ins(ra_d[9], b, {1'b0, fbi_d[0], 3'b000});
            default: ra_d[9] = ins(ra_d[9], b, {1'b1, fbi_d[0], 3'b000});
          endcase
          if (fbi_d[0]) begin
            fbi_d = '0;
            st = 1'b1;
            ck = (phase_d == PH_SIZE) ? CK_AFTER_BODY :
                 (phase_d == PH_OWNER) ? CK_TYPE : CK_PARTY;
          end else begin
            fbi_d = fbi_d + 3'd1;
          end
        end
        PH_FLAGS: begin
          ra_d[4] = {24'd0, b};
          st = 1'b1;
          ck = CK_AFTER_FLAGS;
        end
        PH_EXT: begin
          ra_d[4] = {16'd0, b, ra_d[4][7:0]};
          st = 1'b1;
          ck = CK_COLOR;
        end
        PH_COLOR: begin
          ra_d[5] = ins(ra_d[5], b, {fbi_d[1:0], 3'b000});
          if (fbi_d == 3'd2) begin
            fbi_d = '0;
            ra_d[5][24] = 1'b1;
            st = 1'b1;
            ck = CK_SKIN;
          end else begin
            fbi_d = fbi_d + 3'd1;
          end
        end
        PH_SKIN, PH_NAME, PH_PARTY: begin
          if (b != 8'd0 && phase_d == PH_SKIN) ra_d[7] = ra_d[7] + 32'h0001_0000;
          if (b != 8'd0 && phase_d == PH_NAME) ra_d[8] = ra_d[8] + 32'h0001_0000;
          if (b == 8'd0 || off_d >= len_d) begin
            st = 1'b1;
            ck = (phase_d == PH_SKIN) ? CK_NAME : (phase_d == PH_NAME) ? CK_OWNER : CK_ACCT;
          end
        end
        default: begin
        end
      endcase

      run = st;
      for (int i = 0; i < 10; i++) begin
        f = ra_d[4][7:0];
        if (run) begin
          case (ck)
            CK_EAT: begin
              if (sr_d != 16'd0 && fits(off_d, len_d, 5'd8) && eat_d < EatMax) begin
                phase_d = PH_EAT_PAIR;
                fbi_d = '0;
                ra_d[0] = '0;
                ra_d[1] = '0;
                run = 1'b0;
              end else ck = CK_CELL;
            end
            CK_CELL: begin
              if (fits(off_d, len_d, 5'd4) && cell_d < CellMax) begin
                for (int j = 0; j < 10; j++) ra_d[j] = '0;
                ra_d[9] = {TYPE_NONE, 16'd0};
                phase_d = PH_CELL_ID;
                fbi_d = '0;
                run = 1'b0;
              end else ck = CK_REM;
            end
            CK_AFTER_ID: begin
              if (ra_d[0] == 32'd0 || !fits(off_d, len_d, 5'd10)) ck = CK_REM;
              else begin
                phase_d = PH_X;
                fbi_d = '0;
                ra_d[1] = '0;
                run = 1'b0;
              end
            end
            CK_AFTER_BODY: begin
              if (off_d >= len_d) ck = CK_REM;
              else begin
                phase_d = PH_FLAGS;
                fbi_d = '0;
                ra_d[4] = '0;
                run = 1'b0;
              end
            end
            CK_AFTER_FLAGS: begin
              if (!legacy_q && (f & FLAG_EXT) != 8'd0 && off_d < len_d) begin
                phase_d = PH_EXT;
                fbi_d = '0;
                run = 1'b0;
              end else ck = CK_COLOR;
            end
            CK_COLOR: begin
              if ((f & FLAG_COLOR) != 8'd0 && fits(off_d, len_d, 5'd3)) begin
                phase_d = PH_COLOR;
                fbi_d = '0;
                ra_d[5] = '0;
                run = 1'b0;
              end else ck = CK_SKIN;
            end
            CK_SKIN: begin
              ck = CK_NAME;
              if ((f & FLAG_SKIN) != 8'd0) begin
                ra_d[7] = {16'd0, off_d};
                if (off_d < len_d) begin
                  phase_d = PH_SKIN;
                  run = 1'b0;
                end
              end
            end
            CK_NAME: begin
              ck = CK_OWNER;
              if ((f & FLAG_NAME) != 8'd0) begin
                ra_d[8] = {16'd0, off_d};
                if (off_d < len_d) begin
                  phase_d = PH_NAME;
                  run = 1'b0;
                end
              end
            end
            CK_OWNER: begin
              if (legacy_q && (f & FLAG_OWNER) != 8'd0 && fits(off_d, len_d, 5'd2)) begin
                ra_d[9][15:0] = '0;
                phase_d = PH_OWNER;
                fbi_d = '0;
                run = 1'b0;
              end else ck = CK_TYPE;
            end
            CK_TYPE: begin
              if (legacy_q && (f & FLAG_EXT) != 8'd0 && fits(off_d, len_d, 5'd2)) begin
                ra_d[9][31:16] = '0;
                phase_d = PH_TYPE;
                fbi_d = '0;
                run = 1'b0;
              end else ck = CK_ACCT;
            end
            CK_PARTY: begin
              if (off_d < len_d) begin
                phase_d = PH_PARTY;
                run = 1'b0;
              end else ck = CK_ACCT;
            end
            CK_ACCT: begin
              if ((ra_d[4][15:8] & EXT_ACCT) != 8'd0 && fits(off_d, len_d, 5'd4)) begin
                phase_d = PH_ACCT;
                fbi_d = '0;
                ra_d[6] = '0;
                run = 1'b0;
              end else begin
                x = '0;
                x.record_kind = KIND_CELL;
                x.primary_id = ra_d[0];
                x.second_word = ra_d[1];
                x.y_position = ra_d[2];
                x.cell_size = ra_d[3][15:0];
                x.flag_bytes = ra_d[4][15:0];
                x.color_word = ra_d[5][24:0];
                x.acct_id = ra_d[6];
                x.skin_span = ra_d[7];
                x.name_span = ra_d[8];
                x.owner_and_type = ra_d[9];
                if (n_push == 2'd0) r0 = x;
                else r1 = x;
                n_push = n_push + 2'd1;
                cell_d = cell_d + CW'(1);
                ck = CK_CELL;
              end
            end
            CK_REM: begin
              if (fits(off_d, len_d, 5'd2)) begin
                sr_d = '0;
                phase_d = PH_REM_CNT;
                fbi_d = '0;
              end else phase_d = PH_END;
              run = 1'b0;
            end
            default: begin
              if (sr_d != 16'd0 && fits(off_d, len_d, 5'd4) && rem_d < RemMax) begin
                phase_d = PH_REM_ID;
                fbi_d = '0;
                ra_d[0] = '0;
              end else phase_d = PH_END;
              run = 1'b0;
            end
          endcase
        end
      end

      if (off_d >= len_d) begin
        x = '0;
        x.record_kind = KIND_DONE;
        x.primary_id = 32'(eat_d);
        x.second_word = 32'(cell_d);
        x.y_position = 32'(rem_d);
        if (n_push == 2'd0) r0 = x;
        else r1 = x;
        n_push = n_push + 2'd1;
        phase_d = PH_IDLE;
        off_d = '0;
      end
      if (n_push == 2'd2) r1.last_of_run = 1'b1;
      else if (n_push == 2'd1) r0.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      off_q <= '0;
      len_q <= '0;
      sr_q <= '0;
      fbi_q <= '0;
      eat_q <= '0;
      cell_q <= '0;
      rem_q <= '0;
      for (int i = 0; i < 10; i++) ra_q[i] <= '0;
      legacy_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      off_q <= off_d;
      len_q <= len_d;
      sr_q <= sr_d;
      fbi_q <= fbi_d;
      eat_q <= eat_d;
      cell_q <= cell_d;
      rem_q <= rem_d;
      ra_q <= ra_d;
      if (cfg_i.valid) legacy_q <= cfg_i.legacy_mode;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) fifo_q[wp_q] <= r0;
    if (n_push == 2'd2) fifo_q[wp_q + 2'd1] <= r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      wp_q <= wp_q + n_push;
      if (out_acc) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + {1'b0, n_push} - {2'd0, out_acc};
    end
  end

  assign out_o.valid = (cnt_q != 3'd0);
  assign out_o.record_kind = fifo_q[rp_q].record_kind;
  assign out_o.primary_id = fifo_q[rp_q].primary_id;
  assign out_o.second_word = fifo_q[rp_q].second_word;
  assign out_o.y_position = signed'(fifo_q[rp_q].y_position);
  assign out_o.cell_size = fifo_q[rp_q].cell_size;
  assign out_o.flag_bytes = fifo_q[rp_q].flag_bytes;
  assign out_o.color_word = fifo_q[rp_q].color_word;
  assign out_o.acct_id = fifo_q[rp_q].acct_id;
  assign out_o.skin_span = fifo_q[rp_q].skin_span;
  assign out_o.name_span = fifo_q[rp_q].name_span;
  assign out_o.owner_and_type = fifo_q[rp_q].owner_and_type;
  assign out_o.last_of_run = fifo_q[rp_q].last_of_run;

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4) else $error("output queue overflow");

  a_offset_in_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_IDLE |-> off_q < len_q) else $error("offset past packet end");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.record_kind == KIND_DONE |-> out_o.last_of_run)
    else $error("done record not last");

  a_caps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eat_q <= EatMax && cell_q <= CellMax && rem_q <= RemMax)
    else $error("record count above cap");

endmodule

### bench/cell_update_packet_parser_tb.sv
`timescale 1ns / 100ps

module cell_update_packet_parser_tb;
  import cupp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_BYTES = 120;

  typedef struct {
    logic [7:0]  data;
    logic [15:0] len;
    bit          typed;
    rec_t        want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cupp_in_if  in_if ();
  cupp_cfg_if cfg_if ();
  cupp_out_if out_if ();

  cell_update_packet_parser uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .cfg_i (cfg_if),
    .out_o (out_if)
  );

  always #4 clk = ~clk;

  rec_t expected_recs[$];
  rec_t step_recs[$];
  row_t row_q[$];
  logic [7:0] pkt[$];
  int errors = 0;
  int cycles = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  bit legacy_now = 1'b0;
  bit in_hs, cfg_hs;

  // parser state
  phase_e      ph;
  int unsigned offs, lenh, fbi, remn, eat_t, cell_t, rem_t;
  logic [31:0] ra[10];
  bit          legacy;

  always @(negedge clk) begin
    in_hs  = in_if.valid && in_if.ready;
    cfg_hs = cfg_if.valid && cfg_if.ready;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("cell_update_packet_parser: mismatch");
      $finish;
    end
  end

  function automatic void emit_rec(logic [1:0] kind, logic [31:0] w[10]);
    rec_t r;
    r = '0;
    r.record_kind    = kind;
    r.primary_id     = w[0];
    r.second_word    = w[1];
    r.y_position     = w[2];
    r.cell_size      = w[3][15:0];
    r.flag_bytes     = w[4][15:0];
    r.color_word     = w[5][24:0];
    r.acct_id        = w[6];
    r.skin_span      = w[7];
    r.name_span      = w[8];
    r.owner_and_type = w[9];
    step_recs.push_back(r);
  endfunction

  function automatic void enter(phase_e p, int slot);
    ph  = p;
    fbi = 0;
    if (slot >= 0) ra[slot] = '0;
  endfunction

  function automatic bit gather(int slot, logic [7:0] b, int unsigned cnt, int unsigned base);
    int unsigned sh;
    sh = base + 8 * (fbi & 3);
    ra[slot] |= 32'(b) << sh;
    fbi++;
    if (fbi >= cnt) begin
      fbi = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void settle(check_e ck);
    int unsigned p, len;
    logic [7:0]  f;
    bit          done;
    p = offs;
    len = lenh;
    f = ra[4][7:0];
    done = 1'b0;
    while (!done) begin
      case (ck)
        CK_EAT: begin
          if (remn > 0 && p + 8 <= len && eat_t < 512) begin
            enter(PH_EAT_PAIR, 0);
            ra[1] = '0;
            done = 1'b1;
          end else ck = CK_CELL;
        end
        CK_CELL: begin
          if (p + 4 <= len && cell_t < 2048) begin
            foreach (ra[i]) ra[i] = '0;
            ra[9] = {TYPE_NONE, 16'h0};
            enter(PH_CELL_ID, 0);
            done = 1'b1;
          end else ck = CK_REM;
        end
        CK_AFTER_ID: begin
          if (ra[0] == 0 || p + 10 > len) ck = CK_REM;
          else begin
            enter(PH_X, 1);
            done = 1'b1;
          end
        end
        CK_AFTER_BODY: begin
          if (p >= len) ck = CK_REM;
          else begin
            enter(PH_FLAGS, 4);
            done = 1'b1;
          end
        end
        CK_AFTER_FLAGS: begin
          f = ra[4][7:0];
          if (!legacy && (f & FLAG_EXT) != 0 && p < len) begin
            ph = PH_EXT;
            fbi = 0;
            done = 1'b1;
          end else ck = CK_COLOR;
        end
        CK_COLOR: begin
          if ((f & FLAG_COLOR) != 0 && p + 3 <= len) begin
            enter(PH_COLOR, 5);
            done = 1'b1;
          end else ck = CK_SKIN;
        end
        CK_SKIN: begin
          ck = CK_NAME;
          if ((f & FLAG_SKIN) != 0) begin
            ra[7] = p & 32'hFFFF;
            if (p < len) begin
              ph = PH_SKIN;
              done = 1'b1;
            end
          end
        end
        CK_NAME: begin
          ck = CK_OWNER;
          if ((f & FLAG_NAME) != 0) begin
            ra[8] = p & 32'hFFFF;
            if (p < len) begin
              ph = PH_NAME;
              done = 1'b1;
            end
          end
        end
        CK_OWNER: begin
          if (legacy && (f & FLAG_OWNER) != 0 && p + 2 <= len) begin
            ra[9] &= 32'hFFFF0000;
            ph = PH_OWNER;
            fbi = 0;
            done = 1'b1;
          end else ck = CK_TYPE;
        end
        CK_TYPE: begin
          if (legacy && (f & FLAG_EXT) != 0 && p + 2 <= len) begin
            ra[9] &= 32'h0000FFFF;
            ph = PH_TYPE;
            fbi = 0;
            done = 1'b1;
          end else ck = CK_ACCT;
        end
        CK_PARTY: begin
          if (p < len) begin
            ph = PH_PARTY;
            done = 1'b1;
          end else ck = CK_ACCT;
        end
        CK_ACCT: begin
          if ((ra[4][15:8] & EXT_ACCT) != 0 && p + 4 <= len) begin
            enter(PH_ACCT, 6);
            done = 1'b1;
          end else begin
            emit_rec(KIND_CELL, ra);
            cell_t++;
            ck = CK_CELL;
          end
        end
        CK_REM: begin
          if (p + 2 <= len) begin
            remn = 0;
            ph = PH_REM_CNT;
            fbi = 0;
          end else ph = PH_END;
          done = 1'b1;
        end
        default: begin
          if (remn > 0 && p + 4 <= len && rem_t < 512) enter(PH_REM_ID, 0);
          else ph = PH_END;
          done = 1'b1;
        end
      endcase
    end
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic [15:0] len_in);
    logic [31:0] w[10];
    foreach (w[i]) w[i] = '0;
    step_recs.delete();
    if (ph == PH_IDLE) begin
      lenh = (len_in == 0) ? 1 : len_in;
      offs = 0;
      eat_t = 0;
      cell_t = 0;
      rem_t = 0;
      remn = 0;
      fbi = 0;
      ph = (lenh < 2) ? PH_END : PH_EAT_CNT;
    end
    offs++;
    case (ph)
      PH_EAT_CNT, PH_REM_CNT: begin
        remn |= 32'(b) << (8 * (fbi & 1));
        fbi++;
        if (fbi >= 2) begin
          fbi = 0;
          settle(ph == PH_EAT_CNT ? CK_EAT : CK_REM_LOOP);
        end
      end
      PH_EAT_PAIR: begin
        ra[(fbi >> 2) & 1] |= 32'(b) << (8 * (fbi & 3));
        fbi++;
        if (fbi >= 8) begin
          fbi = 0;
          w[0] = ra[0];
          w[1] = ra[1];
          emit_rec(KIND_EAT, w);
          eat_t++;
          remn = (remn - 1) & 32'hFFFF;
          settle(CK_EAT);
        end
      end
      PH_CELL_ID: if (gather(0, b, 4, 0)) settle(CK_AFTER_ID);
      PH_X:       if (gather(1, b, 4, 0)) enter(PH_Y, 2);
      PH_Y:       if (gather(2, b, 4, 0)) enter(PH_SIZE, 3);
      PH_SIZE:    if (gather(3, b, 2, 0)) settle(CK_AFTER_BODY);
      PH_FLAGS: begin
        ra[4] = 32'(b);
        settle(CK_AFTER_FLAGS);
      end
      PH_EXT: begin
        ra[4] = (ra[4] & 32'hFF) | (32'(b) << 8);
        settle(CK_COLOR);
      end
      PH_COLOR: begin
        if (gather(5, b, 3, 0)) begin
          ra[5] |= 32'h1000000;
          settle(CK_SKIN);
        end
      end
      PH_SKIN, PH_NAME, PH_PARTY: begin
        if (b != 0 && ph != PH_PARTY) ra[ph == PH_SKIN ? 7 : 8] += 32'h10000;
        if (b == 0 || offs >= lenh)
          settle(ph == PH_SKIN ? CK_NAME : ph == PH_NAME ? CK_OWNER : CK_ACCT);
      end
      PH_OWNER: if (gather(9, b, 2, 0)) settle(CK_TYPE);
      PH_TYPE:  if (gather(9, b, 2, 16)) settle(CK_PARTY);
      PH_ACCT: begin
        if (gather(6, b, 4, 0)) begin
          emit_rec(KIND_CELL, ra);
          cell_t++;
          settle(CK_CELL);
        end
      end
      PH_REM_ID: begin
        if (gather(0, b, 4, 0)) begin
          w[0] = ra[0];
          emit_rec(KIND_REMOVE, w);
          rem_t++;
          remn = (remn - 1) & 32'hFFFF;
          settle(CK_REM_LOOP);
        end
      end
      default: ;
    endcase
    if (offs >= lenh) begin
      foreach (w[i]) w[i] = '0;
      w[0] = eat_t;
      w[1] = cell_t;
      w[2] = rem_t;
      emit_rec(KIND_DONE, w);
      ph = PH_IDLE;
      offs = 0;
    end
    if (step_recs.size() > 0) step_recs[step_recs.size() - 1].last_of_run = 1'b1;
  endfunction

  function automatic rec_t done_rec(int e, int c, int r);
    rec_t d;
    d = '0;
    d.record_kind = KIND_DONE;
    d.primary_id = e;
    d.second_word = c;
    d.y_position = r;
    d.last_of_run = 1'b1;
    return d;
  endfunction

  // predict on every accepted byte; typed rows replace the predicted records
  always @(negedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      parse_byte(in_if.data_byte, in_if.packet_length);
      if (row_q.size() > 0 && row_q[0].typed) expected_recs.push_back(row_q[0].want);
      else foreach (step_recs[i]) expected_recs.push_back(step_recs[i]);
      if (row_q.size() > 0) void'(row_q.pop_front());
    end
    if (rst_n && cfg_if.valid && cfg_if.ready) legacy = cfg_if.legacy_mode;
  end

  always @(negedge clk) begin
    rec_t got, want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{out_if.record_kind, out_if.primary_id, out_if.second_word, out_if.y_position,
              out_if.cell_size, out_if.flag_bytes, out_if.color_word, out_if.acct_id,
              out_if.skin_span, out_if.name_span, out_if.owner_and_type, out_if.last_of_run};
      if (expected_recs.size() == 0) begin
        errors++;
        $display("%0t: unexpected item %p", $time, got);
      end else begin
        want = expected_recs.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: expected %p actual %p", $time, want, got);
        end
      end
    end
  end

  // sink side: random stalls, and one long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      out_if.ready <= 1'b1;
    end
  end

  task automatic send_byte(logic [7:0] b, logic [15:0] len);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data_byte <= b;
    in_if.packet_length <= len;
    do @(posedge clk); while (!in_hs);
  endtask

  task automatic push_n(logic [31:0] v, int n);
    for (int i = 0; i < n; i++) pkt.push_back(v[8*i +: 8]);
  endtask

  task automatic push_str();
    repeat ($urandom_range(0, 4)) pkt.push_back(8'($urandom_range(1, 255)));
    pkt.push_back(8'h00);
  endtask

  task automatic build_packet();
    logic [7:0] f, ext;
    int n;
    pkt.delete();
    n = $urandom_range(0, 3);
    push_n(n, 2);
    repeat (2 * n) push_n($urandom, 4);
    repeat ($urandom_range(0, 3)) begin
      push_n($urandom_range(0, 7) == 0 ? 32'hFFFFFFFF : $urandom | 1, 4);
      repeat (2) push_n($urandom, 4);
      push_n($urandom, 2);
      f = 8'($urandom);
      pkt.push_back(f);
      ext = 8'h00;
      if (!legacy_now && f[7]) begin
        ext = 8'($urandom);
        pkt.push_back(ext);
      end
      if (f & FLAG_COLOR) push_n($urandom, 3);
      if (f & FLAG_SKIN) push_str();
      if (f & FLAG_NAME) push_str();
      if (legacy_now && (f & FLAG_OWNER)) push_n($urandom, 2);
      if (legacy_now && (f & FLAG_EXT)) begin
        push_n($urandom, 2);
        push_str();
      end
      if (ext & EXT_ACCT) push_n($urandom, 4);
    end
    push_n(0, 4);
    n = $urandom_range(0, 3);
    push_n(n, 2);
    repeat (n) push_n($urandom, 4);
  endtask

  task automatic send_packet();
    int kind, len;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      pkt.delete();
      repeat ($urandom_range(1, 24)) pkt.push_back(8'($urandom));
    end else build_packet();
    len = pkt.size();
    if (kind == 1 || kind == 2) len = $urandom_range(1, pkt.size());
    else if (kind == 3) repeat ($urandom_range(1, 8)) pkt.push_back(8'($urandom));
    for (int i = 0; i < pkt.size() && i < len || (kind == 3 && i < pkt.size()); i++)
      send_byte(pkt[i], i == 0 ? 16'(kind == 3 ? pkt.size() : len) : 16'($urandom));
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (expected_recs.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_legacy(bit v);
    cfg_if.valid <= 1'b1;
    cfg_if.legacy_mode <= v;
    do @(posedge clk); while (!cfg_hs);
    cfg_if.valid <= 1'b0;
    legacy_now = v;
  endtask

  initial begin
    int sent;
    row_t rows[$];
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.packet_length = '0;
    cfg_if.valid = 1'b0;
    cfg_if.legacy_mode = 1'b0;
    ph = PH_IDLE;
    offs = 0; lenh = 0; fbi = 0; remn = 0;
    eat_t = 0; cell_t = 0; rem_t = 0;
    legacy = 1'b0;
    foreach (ra[i]) ra[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    row_q.push_back('{8'hFF, 16'd1, 1'b1, done_rec(0, 0, 0)});
    row_q.push_back('{8'h00, 16'd0, 1'b1, done_rec(0, 0, 0)});
    row_q.push_back('{8'h00, 16'd2, 1'b0, '0});
    row_q.push_back('{8'h00, 16'hFFFF, 1'b1, done_rec(0, 0, 0)});
    row_q.push_back('{8'hFF, 16'd12, 1'b0, '0});
    row_q.push_back('{8'hFF, 16'h0000, 1'b0, '0});
    for (int i = 0; i < 8; i++) row_q.push_back('{8'(8'hA5 ^ i), 16'hFFFF, 1'b0, '0});
    row_q.push_back('{8'h01, 16'h0000, 1'b0, '0});
    row_q.push_back('{8'h00, 16'hFFFF, 1'b0, '0});
    row_q.push_back('{8'h03, 16'd3, 1'b0, '0});
    row_q.push_back('{8'hFF, 16'h8000, 1'b0, '0});
    row_q.push_back('{8'h7F, 16'h7FFF, 1'b1, done_rec(0, 0, 0)});
    rows = row_q;
    foreach (rows[i]) send_byte(rows[i].data, rows[i].len);

    for (int stage = 0; stage < 4; stage++) begin
      if (stage > 0) begin
        drain();
        write_legacy(stage[0]);
      end
      if (stage == 2) hold_req = 1'b1;
      if (stage == 3) idle_on = 1'b0;
      sent = 0;
      while (sent < PHASE_BYTES) begin
        send_packet();
        sent += pkt.size();
      end
    end
    drain();
    if (errors == 0 && expected_recs.size() == 0) begin
      $display("cell_update_packet_parser: match");
    end else begin
      $display("cell_update_packet_parser: mismatch");
    end
    $finish;
  end

endmodule
